@@ hdl/gls_pkg.sv @@
// Shared types and constants for the grid line-of-sight tracer.
// Used by gls_ctrl, gls_dp and grid_line_of_sight; no dependencies.
`timescale 1ns / 1ps

package gls_pkg;

  // Coordinate field width and the width that holds a map dimension (up to 511)
  localparam int COORD_W = 6;
  localparam int DIM_W   = 9;
  // Error accumulators grow along the major axis; 12 bits cover 63 steps of 63
  localparam int ACC_W   = 12;

  // Stream payload widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  // Bit offsets of the input fields in s_axis_tdata
  localparam int FROM_X_LSB  = 0;
  localparam int FROM_Y_LSB  = 6;
  localparam int TO_X_LSB    = 12;
  localparam int TO_Y_LSB    = 18;
  localparam int SEE_THR_BIT = 24;

  // Opcodes carried in s_axis_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_tile;   // store one tile bit
    logic load;      // latch start and target of a trace
    logic move;      // opaque start: move one tile toward the target
    logic seed;      // compute distances and seed the accumulators
    logic step;      // advance one tile along the path
    logic finish;    // capture the trace answer
    logic out_load;  // hand the answer to the output register
  } gls_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic at_target;   // current tile is the target
    logic tile_clear;  // current tile is on the map and transparent
    logic out_free;    // output register can take a beat this cycle
  } gls_sts_t;

endpackage

@@ hdl/grid_line_of_sight.sv @@
// Grid line-of-sight tracer over a one-bit-per-tile transparency map.
// Use: input beats on s_axis carry either a tile write (tuser = 0) or a trace
//   request (tuser = 1); each trace returns one beat on m_axis, writes none.
// Writes are taken while idle; s_axis_tready stays high for back-to-back writes.
// A trace holds s_axis_tready low through its start, seed, step and output
//   hand-off states; it steps k tiles on a clear path, fewer when an opaque
//   tile ends it early, where k is the longer axis distance left after the
//   opaque-start move (0 to 63), reading each tile from the single read port
//   of the map memory, and a final check ends the steps. The result beat is
//   valid on the clock edge after the hand-off; the next beat is taken then.
// The output register holds one finished beat; a new trace runs while it
//   waits and, if m_axis_tready stays low, stalls in its hand-off cycle.
// Reset clears the sequencer and the output valid; map contents are undefined
//   until written and are never cleared. Writes off the map are dropped, and
//   off-map tiles read as opaque during a trace.
// Depends on gls_pkg, gls_ctrl and gls_dp.
`timescale 1ns / 1ps

module grid_line_of_sight
  import gls_pkg::*;
#(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // from_x[5:0], from_y[11:6], to_x[17:12], to_y[23:18], see_through[24], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // visible[0], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  gls_cmd_t cmd;
  gls_sts_t sts;
  logic     visible;

  gls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gls_dp #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .from_x_i      (s_axis_tdata[FROM_X_LSB +: COORD_W]),
    .from_y_i      (s_axis_tdata[FROM_Y_LSB +: COORD_W]),
    .to_x_i        (s_axis_tdata[TO_X_LSB +: COORD_W]),
    .to_y_i        (s_axis_tdata[TO_Y_LSB +: COORD_W]),
    .see_through_i (s_axis_tdata[SEE_THR_BIT]),
    .out_ready_i   (m_axis_tready),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .visible_o     (visible)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, visible};

`ifndef ASSERT_OFF
  // A trace beat makes the block busy on the next cycle
  a_trace_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TRACE)) |=> !s_axis_tready)
    else $error("trace accepted but input still ready");

  // The output register is never loaded over a pending beat
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending output beat");

  // A new result is only loaded while the block is busy
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !s_axis_tready)
    else $error("result produced while idle");

  // Stepping never happens on the target tile or a blocked tile
  a_step_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> (sts.tile_clear && !sts.at_target))
    else $error("step issued on target or blocked tile");
`endif

endmodule

@@ hdl/gls_ctrl.sv @@
// Sequencer for the line-of-sight tracer: accepts beats and steps a trace.
// Depends on gls_pkg for the command and status structs and opcodes.
`timescale 1ns / 1ps

module gls_ctrl
  import gls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     opcode_i,
  output logic     in_ready_o,
  input  gls_sts_t sts_i,
  output gls_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_SEED  = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == OP_TRACE) begin
            cmd_o.load = 1'b1;
            state_d    = ST_START;
          end else begin
            cmd_o.wr_tile = 1'b1;
          end
        end
      end
      ST_START: begin
        cmd_o.move = !sts_i.tile_clear;
        state_d    = ST_SEED;
      end
      ST_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = ST_STEP;
      end
      ST_STEP: begin
        if (sts_i.at_target || !sts_i.tile_clear) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_OUT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/gls_dp.sv @@
// Datapath of the tracer: tile map memory, position, error accumulators, output.
// Depends on gls_pkg; driven by gls_ctrl through gls_cmd_t.
`timescale 1ns / 1ps

module gls_dp
  import gls_pkg::*;
#(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gls_cmd_t           cmd_i,
  input  logic [COORD_W-1:0] from_x_i,
  input  logic [COORD_W-1:0] from_y_i,
  input  logic [COORD_W-1:0] to_x_i,
  input  logic [COORD_W-1:0] to_y_i,
  input  logic               see_through_i,
  input  logic               out_ready_i,
  output gls_sts_t           sts_o,
  output logic               out_valid_o,
  output logic               visible_o
);

  localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIN_W  = 2 * DIM_W;

  // One step from a toward b, or stay when equal
  function automatic logic [COORD_W-1:0] toward(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] r;
    r = a;
    if (a < b) begin
      r = a + COORD_W'(1);
    end else if (a > b) begin
      r = a - COORD_W'(1);
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic off_map(input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y);
    return (DIM_W'(x) >= DIM_W'(MAP_WIDTH)) || (DIM_W'(y) >= DIM_W'(MAP_HEIGHT));
  endfunction

  function automatic logic [LIN_W-1:0] lin_addr(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y);
    return LIN_W'(y) * LIN_W'(MAP_WIDTH) + LIN_W'(x);
  endfunction

  logic               mem [DEPTH];
  logic [COORD_W-1:0] px_q, px_d, py_q, py_d, tx_q, tx_d, ty_q, ty_d;
  logic [COORD_W-1:0] adx_q, adx_d, ady_q, ady_d, adx_c, ady_c;
  logic [ACC_W-1:0]   ex_q, ex_d, ey_q, ey_d, ex_sum, ey_sum;
  logic               x_step, y_step;
  logic               rd_oob, wr_oob, oob_q, rd_bit_q;
  logic [LIN_W-1:0]   rd_lin, wr_lin;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               res_q, out_valid_q, out_vis_q;

  // Distances and accumulator steps
  assign adx_c  = abs_diff(px_q, tx_q);
  assign ady_c  = abs_diff(py_q, ty_q);
  assign ex_sum = ex_q + ACC_W'(adx_q);
  assign ey_sum = ey_q + ACC_W'(ady_q);
  assign x_step = ex_sum >= ACC_W'(ady_q);
  assign y_step = ey_sum >= ACC_W'(adx_q);

  // Position, target and accumulator updates
  always_comb begin
    px_d  = px_q;
    py_d  = py_q;
    tx_d  = tx_q;
    ty_d  = ty_q;
    adx_d = adx_q;
    ady_d = ady_q;
    ex_d  = ex_q;
    ey_d  = ey_q;
    priority if (cmd_i.load) begin
      px_d = from_x_i;
      py_d = from_y_i;
      tx_d = to_x_i;
      ty_d = to_y_i;
    end else if (cmd_i.move) begin
      px_d = toward(px_q, tx_q);
      py_d = toward(py_q, ty_q);
    end else if (cmd_i.seed) begin
      adx_d = adx_c;
      ady_d = ady_c;
      ex_d  = ACC_W'(ady_c[COORD_W-1:1]);
      ey_d  = ACC_W'(adx_c[COORD_W-1:1]);
    end else if (cmd_i.step) begin
      ex_d = x_step ? (ex_sum - ACC_W'(ady_q)) : ex_sum;
      ey_d = y_step ? (ey_sum - ACC_W'(adx_q)) : ey_sum;
      if (x_step) begin
        px_d = toward(px_q, tx_q);
      end
      if (y_step) begin
        py_d = toward(py_q, ty_q);
      end
    end else begin
      // no command: hold everything
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    tx_q  <= tx_d;
    ty_q  <= ty_d;
    adx_q <= adx_d;
    ady_q <= ady_d;
    ex_q  <= ex_d;
    ey_q  <= ey_d;
  end

  // Map addresses; the read follows the next position so data lines up with it
  assign rd_oob  = off_map(px_d, py_d);
  assign wr_oob  = off_map(from_x_i, from_y_i);
  assign rd_lin  = lin_addr(px_d, py_d);
  assign wr_lin  = lin_addr(from_x_i, from_y_i);
  assign rd_addr = rd_oob ? '0 : rd_lin[ADDR_W-1:0];
  assign wr_addr = wr_oob ? '0 : wr_lin[ADDR_W-1:0];

  // Tile map memory, one bit per tile, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tile && !wr_oob) begin
      mem[wr_addr] <= see_through_i;
    end
    rd_bit_q <= mem[rd_addr];
    oob_q    <= rd_oob;
  end

  // Trace answer
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q <= sts_o.at_target;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_vis_q <= res_q;
    end
  end

  assign sts_o.at_target  = (px_q == tx_q) && (py_q == ty_q);
  assign sts_o.tile_clear = rd_bit_q && !oob_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign visible_o        = out_vis_q;

endmodule
